// ===== rtl/push_button_power_sequencer_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef PUSH_BUTTON_POWER_SEQUENCER_CORE_ASSERT_SVH
`define PUSH_BUTTON_POWER_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PBPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PBPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/pbps_pkg.sv =====
`default_nettype none
package pbps_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int MV_W         = 14;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // mv = floor(x * 34925 / 9 / 2^(ADC_BITS-2)); 34925 = 9*3880 + 5
  localparam int MV_WHOLE  = 3880;
  localparam int MV_FRAC   = 5;
  localparam int MV_RECIP  = 466034;
  localparam int MV_RECIP_W = 19;
  localparam int MV_SHIFT  = 22;

  localparam logic [2:0] MODE_ASLEEP   = 3'd0;
  localparam logic [2:0] MODE_PENDING  = 3'd1;
  localparam logic [2:0] MODE_HOLD     = 3'd2;
  localparam logic [2:0] MODE_RELSTART = 3'd3;
  localparam logic [2:0] MODE_RUN      = 3'd4;
  localparam logic [2:0] MODE_RELSTOP  = 3'd5;

  localparam logic [1:0] PHASE_STEADY = 2'd0;
  localparam logic [1:0] PHASE_DARK   = 2'd1;
  localparam logic [1:0] PHASE_LIT    = 2'd2;
  localparam logic [1:0] PHASE_SPARE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_START_HOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_HOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_MV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_MV      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_OFF    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON     = 3'd6;

  localparam logic [7:0]      START_HOLD_RST   = 8'd50;
  localparam logic [7:0]      STOP_HOLD_RST    = 8'd100;
  localparam logic [MV_W-1:0] CUTOFF_MV_RST    = 14'd6500;
  localparam logic [7:0]      CUTOFF_TICKS_RST = 8'd40;
  localparam logic [MV_W-1:0] WARN_MV_RST      = 14'd7000;
  localparam logic [15:0]     BLINK_OFF_RST    = 16'd10;
  localparam logic [15:0]     BLINK_ON_RST     = 16'd190;

  typedef struct packed {
    logic [7:0]      start_hold_ticks;
    logic [7:0]      stop_hold_ticks;
    logic [MV_W-1:0] cutoff_mv;
    logic [7:0]      cutoff_ticks;
    logic [MV_W-1:0] warn_mv;
    logic [15:0]     blink_off_ticks;
    logic [15:0]     blink_on_ticks;
  } cfg_t;

  typedef struct packed {
    logic            pressed;
    logic            charging;
    logic [MV_W-1:0] mv;
  } tick_t;

endpackage
`default_nettype wire

// ===== rtl/pbps_conv.sv =====
`default_nettype none
module pbps_conv
  import pbps_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                load,
  input  wire logic                pressed,
  input  wire logic                charging,
  input  wire logic [ADC_BITS-1:0] sample,
  output tick_t                    tick
);

  localparam int HW = ADC_BITS + 12;
  localparam int YW = ADC_BITS + 3;
  localparam int LW = YW + MV_RECIP_W;

  logic          pressed_q;
  logic          charging_q;
  logic [HW-1:0] prod_whole;
  logic [LW-1:0] prod_frac;
  logic [YW-1:0] frac_num;
  logic [HW-1:0] mv_sum;

  assign frac_num = YW'(sample) * YW'(MV_FRAC);

  always_ff @(posedge clk) begin
    if (load) begin
      pressed_q  <= pressed;
      charging_q <= charging;
      prod_whole <= HW'(sample) * HW'(MV_WHOLE);
      prod_frac  <= LW'(frac_num) * LW'(MV_RECIP);
    end
  end

  assign mv_sum = prod_whole + HW'(prod_frac[LW-1:MV_SHIFT]);

  assign tick.pressed  = pressed_q;
  assign tick.charging = charging_q;
  assign tick.mv       = MV_W'(mv_sum >> (ADC_BITS - 2));

endmodule
`default_nettype wire

// ===== rtl/pbps_step.sv =====
`default_nettype none
module pbps_step
  import pbps_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  tick_t                tick,
  input  cfg_t                 cfg,
  output logic                 rails_on,
  output logic                 green_led,
  output logic                 orange_led,
  output logic [2:0]           mode,
  output logic [MV_W-1:0]      battery_mv
);

  logic [2:0]      mode_reg, mode_next;
  logic [7:0]      press_count, press_count_next;
  logic [7:0]      low_batt_count, low_batt_count_next;
  logic [1:0]      blink_phase, blink_phase_next;
  logic [15:0]     blink_count, blink_count_next;
  logic [1:0]      led_bits, led_bits_next;
  logic            rails_reg, rails_next;
  logic [MV_W-1:0] battery_reg, battery_next;

  function automatic logic [7:0] sat8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  always_comb begin
    logic [2:0] m;
    m                   = mode_reg;
    press_count_next    = press_count;
    low_batt_count_next = low_batt_count;
    blink_phase_next    = blink_phase;
    blink_count_next    = blink_count;
    led_bits_next       = led_bits;
    rails_next          = rails_reg;
    battery_next        = battery_reg;

    if (m == MODE_PENDING) begin
      led_bits_next    = 2'b00;
      rails_next       = 1'b0;
      press_count_next = '0;
      m                = MODE_ASLEEP;
    end else if (m == MODE_ASLEEP && tick.pressed) begin
      m = MODE_HOLD;
    end

    if (m == MODE_HOLD) begin
      led_bits_next[0] = 1'b1;
      if (tick.pressed) begin
        press_count_next = sat8(press_count_next);
        if (press_count_next > cfg.start_hold_ticks) m = MODE_RELSTART;
      end else begin
        press_count_next = '0;
        m                = MODE_PENDING;
      end
    end

    if (m == MODE_RELSTART) begin
      led_bits_next[1] = 1'b1;
      if (!tick.pressed) begin
        led_bits_next = 2'b01;
        rails_next    = 1'b1;
        m             = MODE_RUN;
      end
    end

    if (m == MODE_RELSTOP) begin
      led_bits_next[0] = 1'b0;
      if (!tick.pressed) m = MODE_PENDING;
    end

    mode_next = m;

    if (m == MODE_RUN) begin
      battery_next     = tick.mv;
      led_bits_next[1] = tick.charging;

      if (tick.pressed) begin
        press_count_next = sat8(press_count_next);
        if (press_count_next > cfg.stop_hold_ticks) mode_next = MODE_RELSTOP;
      end else begin
        press_count_next = '0;
      end

      if (tick.mv < cfg.cutoff_mv) begin
        low_batt_count_next = sat8(low_batt_count_next);
        if (low_batt_count_next > cfg.cutoff_ticks) mode_next = MODE_RELSTOP;
      end else begin
        low_batt_count_next = '0;
      end

      if (tick.mv < cfg.warn_mv) begin
        if (blink_phase_next == PHASE_STEADY) blink_phase_next = PHASE_DARK;
      end else begin
        blink_phase_next = PHASE_STEADY;
      end

      if (blink_count_next != 16'hFFFF) blink_count_next = blink_count_next + 16'd1;
      if (blink_phase_next == PHASE_DARK && blink_count_next > cfg.blink_off_ticks) begin
        led_bits_next[0] = 1'b1;
        blink_count_next = '0;
        blink_phase_next = PHASE_LIT;
      end
      if (blink_phase_next == PHASE_LIT && blink_count_next > cfg.blink_on_ticks) begin
        led_bits_next[0] = 1'b0;
        blink_count_next = '0;
        blink_phase_next = PHASE_DARK;
      end
      if (blink_phase_next == PHASE_STEADY || blink_phase_next == PHASE_SPARE) begin
        led_bits_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= MODE_RELSTART;
      press_count    <= '0;
      low_batt_count <= '0;
      blink_phase    <= PHASE_STEADY;
      blink_count    <= '0;
      led_bits       <= 2'b00;
      rails_reg      <= 1'b0;
      battery_reg    <= '0;
    end else if (adv) begin
      mode_reg       <= mode_next;
      press_count    <= press_count_next;
      low_batt_count <= low_batt_count_next;
      blink_phase    <= blink_phase_next;
      blink_count    <= blink_count_next;
      led_bits       <= led_bits_next;
      rails_reg      <= rails_next;
      battery_reg    <= battery_next;
    end
  end

  assign rails_on   = rails_reg;
  assign green_led  = led_bits[0];
  assign orange_led = led_bits[1];
  assign mode       = mode_reg;
  assign battery_mv = battery_reg;

endmodule
`default_nettype wire

// ===== rtl/push_button_power_sequencer_core.sv =====
// Push-button power sequencer, one input beat per 10 ms tick.
// Input channel (in_valid/in_ready): button_pressed, charging and the raw
// battery_sample. Output channel (out_valid/out_ready): rails_on, the two
// LED drives, the mode code and the last battery voltage in millivolts.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the seven
// threshold registers; cfg_ready is always high, unknown indexes are dropped.
// Write config only while no tick is in flight.
// Pipeline: input register, millivolt multiply register, then the mode step
// whose state registers are the result register. One beat is accepted every
// cycle unless the pipeline is full and out_ready is low.
// The state step runs once per beat, as the beat moves into the
// result register.
// When out_ready is low the three stages fill and in_ready drops after up to
// three more beats; nothing is lost.
// Reset empties the pipeline, loads the default thresholds and puts the mode
// to wait-release-start with rails and LEDs off.
`default_nettype none
module push_button_power_sequencer_core
  import pbps_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  button_pressed,
  input  wire logic                  charging,
  input  wire logic [ADC_BITS-1:0]   battery_sample,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       rails_on,
  output logic                       green_led,
  output logic                       orange_led,
  output logic [2:0]                 mode,
  output logic [MV_W-1:0]            battery_mv,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic                v0, v1, v2;
  logic                r0, r1, r2;
  logic                pressed0, charging0;
  logic [ADC_BITS-1:0] sample0;
  tick_t               tick1;
  cfg_t                cfg;

  assign r2       = !v2 || out_ready;
  assign r1       = !v1 || r2;
  assign r0       = !v0 || r1;
  assign in_ready = r0;
  assign out_valid = v2;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (r0) v0 <= in_valid;
      if (r1) v1 <= v0;
      if (r2) v2 <= v1;
    end
  end

  // hold the incoming beat
  always_ff @(posedge clk) begin
    if (in_valid && r0) begin
      pressed0  <= button_pressed;
      charging0 <= charging;
      sample0   <= battery_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_hold_ticks <= START_HOLD_RST;
      cfg.stop_hold_ticks  <= STOP_HOLD_RST;
      cfg.cutoff_mv        <= CUTOFF_MV_RST;
      cfg.cutoff_ticks     <= CUTOFF_TICKS_RST;
      cfg.warn_mv          <= WARN_MV_RST;
      cfg.blink_off_ticks  <= BLINK_OFF_RST;
      cfg.blink_on_ticks   <= BLINK_ON_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_HOLD:   cfg.start_hold_ticks <= cfg_data[7:0];
        REG_STOP_HOLD:    cfg.stop_hold_ticks  <= cfg_data[7:0];
        REG_CUTOFF_MV:    cfg.cutoff_mv        <= cfg_data[MV_W-1:0];
        REG_CUTOFF_TICKS: cfg.cutoff_ticks     <= cfg_data[7:0];
        REG_WARN_MV:      cfg.warn_mv          <= cfg_data[MV_W-1:0];
        REG_BLINK_OFF:    cfg.blink_off_ticks  <= cfg_data;
        REG_BLINK_ON:     cfg.blink_on_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  pbps_conv #(
    .ADC_BITS(ADC_BITS)
  ) u_conv (
    .clk      (clk),
    .load     (v0 && r1),
    .pressed  (pressed0),
    .charging (charging0),
    .sample   (sample0),
    .tick     (tick1)
  );

  pbps_step u_step (
    .clk        (clk),
    .rst        (rst),
    .adv        (v1 && r2),
    .tick       (tick1),
    .cfg        (cfg),
    .rails_on   (rails_on),
    .green_led  (green_led),
    .orange_led (orange_led),
    .mode       (mode),
    .battery_mv (battery_mv)
  );

endmodule
`default_nettype wire

// ===== rtl/pbps_checker.sv =====
`default_nettype none
`include "push_button_power_sequencer_core_assert.svh"
module pbps_checker
  import pbps_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic            rails_on,
  input wire logic            green_led,
  input wire logic            orange_led,
  input wire logic [2:0]      mode,
  input wire logic [MV_W-1:0] battery_mv
);

  `PBPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mode) && $stable(battery_mv) && $stable(rails_on))
  `PBPS_ASSERT_NOW(a_rails_off_idle, out_valid && (mode == MODE_ASLEEP || mode == MODE_HOLD), !rails_on)
  `PBPS_ASSERT_NOW(a_rails_on_run, out_valid && (mode == MODE_RUN || mode == MODE_RELSTOP), rails_on)
  `PBPS_ASSERT_NOW(a_dark_asleep, out_valid && mode == MODE_ASLEEP, !green_led && !orange_led)

endmodule

bind push_button_power_sequencer_core pbps_checker u_pbps_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .rails_on   (rails_on),
  .green_led  (green_led),
  .orange_led (orange_led),
  .mode       (mode),
  .battery_mv (battery_mv)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import pbps_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 150;
  localparam int GREEN_BIT = 0;
  localparam int ORANGE_BIT = 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic            rails;
    logic            green;
    logic            orange;
    logic [2:0]      mode;
    logic [MV_W-1:0] mv;
  } seq_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic button_pressed = 1'b0;
  logic charging = 1'b0;
  logic [ADC_BITS_DEF-1:0] battery_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic rails_on;
  logic green_led;
  logic orange_led;
  logic [2:0] mode;
  logic [MV_W-1:0] battery_mv;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t thr = '{START_HOLD_RST, STOP_HOLD_RST, CUTOFF_MV_RST, CUTOFF_TICKS_RST,
                WARN_MV_RST, BLINK_OFF_RST, BLINK_ON_RST};
  logic [2:0] seq_mode = MODE_RELSTART;
  logic [7:0] press_cnt = '0;
  logic [7:0] low_cnt = '0;
  logic [1:0] blink_phase = PHASE_STEADY;
  logic [15:0] blink_cnt = '0;
  logic [1:0] led_bits = '0;
  logic rails_en = 1'b0;
  logic [MV_W-1:0] batt_mv = '0;

  seq_out_t predicted_outputs[$];
  int mismatches = 0;
  int idle_run = 0;
  int gap_odds = 8;
  int stall_odds = 8;
  bit long_hold_req = 1'b0;

  push_button_power_sequencer_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .button_pressed(button_pressed),
    .charging(charging),
    .battery_sample(battery_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rails_on(rails_on),
    .green_led(green_led),
    .orange_led(orange_led),
    .mode(mode),
    .battery_mv(battery_mv),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] bump(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic seq_out_t step_sequencer(input logic pressed, input logic chg,
                                              input logic [ADC_BITS_DEF-1:0] sample);
    longint unsigned scaled;
    logic [MV_W-1:0] mv;
    seq_out_t r;
    scaled = sample;
    scaled = scaled * 3300 * 127 / 27;
    mv = MV_W'(scaled >> ADC_BITS_DEF);

    if (seq_mode == MODE_PENDING) begin
      led_bits = 2'b00;
      rails_en = 1'b0;
      press_cnt = '0;
      seq_mode = MODE_ASLEEP;
    end else if (seq_mode == MODE_ASLEEP && pressed) begin
      seq_mode = MODE_HOLD;
    end

    if (seq_mode == MODE_HOLD) begin
      led_bits[GREEN_BIT] = 1'b1;
      if (pressed) begin
        press_cnt = bump(press_cnt);
        if (press_cnt > thr.start_hold_ticks) seq_mode = MODE_RELSTART;
      end else begin
        press_cnt = '0;
        seq_mode = MODE_PENDING;
      end
    end

    if (seq_mode == MODE_RELSTART) begin
      if (pressed) begin
        led_bits[ORANGE_BIT] = 1'b1;
      end else begin
        led_bits[ORANGE_BIT] = 1'b0;
        led_bits[GREEN_BIT] = 1'b1;
        rails_en = 1'b1;
        seq_mode = MODE_RUN;
      end
    end

    if (seq_mode == MODE_RELSTOP) begin
      led_bits[GREEN_BIT] = 1'b0;
      if (!pressed) seq_mode = MODE_PENDING;
    end

    if (seq_mode == MODE_RUN) begin
      batt_mv = mv;
      led_bits[ORANGE_BIT] = chg;
      if (pressed) begin
        press_cnt = bump(press_cnt);
        if (press_cnt > thr.stop_hold_ticks) seq_mode = MODE_RELSTOP;
      end else begin
        press_cnt = '0;
      end
      if (mv < thr.cutoff_mv) begin
        low_cnt = bump(low_cnt);
        if (low_cnt > thr.cutoff_ticks) seq_mode = MODE_RELSTOP;
      end else begin
        low_cnt = '0;
      end
      if (mv < thr.warn_mv) begin
        if (blink_phase == PHASE_STEADY) blink_phase = PHASE_DARK;
      end else begin
        blink_phase = PHASE_STEADY;
      end
      if (blink_cnt != 16'hFFFF) blink_cnt = blink_cnt + 16'd1;
      if (blink_phase == PHASE_DARK && blink_cnt > thr.blink_off_ticks) begin
        led_bits[GREEN_BIT] = 1'b1;
        blink_cnt = '0;
        blink_phase = PHASE_LIT;
      end
      if (blink_phase == PHASE_LIT && blink_cnt > thr.blink_on_ticks) begin
        led_bits[GREEN_BIT] = 1'b0;
        blink_cnt = '0;
        blink_phase = PHASE_DARK;
      end
      if (blink_phase == PHASE_STEADY || blink_phase == PHASE_SPARE)
        led_bits[GREEN_BIT] = 1'b1;
    end

    r.rails = rails_en;
    r.green = led_bits[GREEN_BIT];
    r.orange = led_bits[ORANGE_BIT];
    r.mode = seq_mode;
    r.mv = batt_mv;
    return r;
  endfunction

  function automatic int mv_to_sample(input logic [MV_W-1:0] mv);
    longint s;
    s = longint'(mv) * 27 * 4096 / 419100;
    return (s > 4095) ? 4095 : int'(s);
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 4;
      2: return 12;
      default: return 30;
    endcase
  endfunction

  function automatic cfg_t random_thresholds();
    cfg_t c;
    c.start_hold_ticks = 8'($urandom_range(0, 6));
    c.stop_hold_ticks = 8'($urandom_range(0, 8));
    c.cutoff_mv = 14'($urandom_range(3000, 12000));
    c.cutoff_ticks = 8'($urandom_range(0, 8));
    c.warn_mv = 14'($urandom_range(3000, 14000));
    c.blink_off_ticks = 16'($urandom_range(0, 6));
    c.blink_on_ticks = 16'($urandom_range(0, 6));
    return c;
  endfunction

  task automatic send_tick(input logic pressed, input logic chg,
                           input logic [ADC_BITS_DEF-1:0] sample);
    in_valid <= 1'b1;
    button_pressed <= pressed;
    charging <= chg;
    battery_sample <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted_outputs.push_back(step_sequencer(pressed, chg, sample));
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_START_HOLD:   thr.start_hold_ticks = data[7:0];
      REG_STOP_HOLD:    thr.stop_hold_ticks = data[7:0];
      REG_CUTOFF_MV:    thr.cutoff_mv = data[MV_W-1:0];
      REG_CUTOFF_TICKS: thr.cutoff_ticks = data[7:0];
      REG_WARN_MV:      thr.warn_mv = data[MV_W-1:0];
      REG_BLINK_OFF:    thr.blink_off_ticks = data;
      REG_BLINK_ON:     thr.blink_on_ticks = data;
      default: ;
    endcase
  endtask

  task automatic program_thresholds(input cfg_t c);
    logic [15:0] junk;
    junk = 16'($urandom());
    wait_for_results();
    write_reg(REG_START_HOLD, {junk[15:8], c.start_hold_ticks});
    write_reg(REG_STOP_HOLD, {junk[7:0], c.stop_hold_ticks});
    write_reg(REG_CUTOFF_MV, {junk[15:14], c.cutoff_mv});
    write_reg(REG_CUTOFF_TICKS, {junk[11:4], c.cutoff_ticks});
    write_reg(REG_WARN_MV, {junk[1:0], c.warn_mv});
    write_reg(REG_BLINK_OFF, c.blink_off_ticks);
    write_reg(REG_BLINK_ON, c.blink_on_ticks);
    write_reg(REG_UNUSED, ~junk);
    cfg_valid <= 1'b0;
  endtask

  task automatic steer_to_run();
    while (seq_mode != MODE_RUN)
      send_tick(seq_mode == MODE_ASLEEP || seq_mode == MODE_HOLD, 1'b0, 12'hFFF);
  endtask

  task automatic random_traffic(input int n_items);
    int press_left;
    int zone;
    int cut_s;
    int warn_s;
    logic pressed;
    logic [ADC_BITS_DEF-1:0] sample;
    press_left = 0;
    zone = 3;
    for (int i = 0; i < n_items; i++) begin
      if (press_left > 0) begin
        pressed = 1'b1;
        press_left--;
      end else begin
        case (seq_mode) inside
          MODE_ASLEEP: begin
            pressed = 1'(($urandom_range(0, 1)));
            if (pressed) begin
              press_left = ($urandom_range(0, 6) != 0)
                         ? int'(thr.start_hold_ticks) + int'($urandom_range(1, 3))
                         : int'($urandom_range(1, int'(thr.start_hold_ticks) + 1));
              press_left--;
            end
          end
          MODE_RUN: begin
            pressed = ($urandom_range(0, 39) == 0);
            if (pressed) begin
              press_left = ($urandom_range(0, 4) != 0)
                         ? int'(thr.stop_hold_ticks) + int'($urandom_range(1, 3))
                         : int'($urandom_range(1, int'(thr.stop_hold_ticks) + 1));
              press_left--;
            end
          end
          MODE_HOLD: pressed = 1'b0;
          MODE_RELSTART, MODE_RELSTOP: pressed = ($urandom_range(0, 2) == 0);
          default: pressed = 1'(($urandom_range(0, 1)));
        endcase
      end
      if ($urandom_range(0, 24) == 0) pressed = ~pressed;

      if ($urandom_range(0, 15) == 0) zone = $urandom_range(0, 3);
      cut_s = mv_to_sample(thr.cutoff_mv);
      warn_s = mv_to_sample(thr.warn_mv);
      case (zone)
        0: sample = 12'($urandom_range(0, cut_s));
        1: sample = 12'($urandom_range(cut_s, warn_s));
        2: sample = 12'($urandom_range(warn_s, 4095));
        default: sample = 12'($urandom_range(0, 4095));
      endcase
      send_tick(pressed, 1'(($urandom_range(0, 1))), sample);
    end
  endtask

  task automatic test_directed();
    cfg_t c;
    c = '{8'd2, 8'd2, 14'd6500, 8'd1, 14'd7000, 16'd1, 16'd2};
    program_thresholds(c);
    send_tick(1'b1, 1'b0, 12'd0);
    send_tick(1'b0, 1'b1, 12'hFFF);
    repeat (4) send_tick(1'b0, 1'b0, 12'd1800);
    repeat (3) send_tick(1'b0, 1'b1, 12'd0);
    send_tick(1'b0, 1'b0, 12'd0);
    send_tick(1'b0, 1'b0, 12'd0);
    send_tick(1'b1, 1'b0, 12'd0);
    send_tick(1'b0, 1'b0, 12'd0);
    send_tick(1'b1, 1'b0, 12'd0);
    repeat (3) send_tick(1'b1, 1'b0, 12'd2048);
    send_tick(1'b1, 1'b0, 12'd2048);
    send_tick(1'b0, 1'b0, 12'd2048);
    repeat (3) send_tick(1'b1, 1'b1, 12'd2048);
    send_tick(1'b1, 1'b0, 12'd2048);
    send_tick(1'b0, 1'b0, 12'd2048);
  endtask

  task automatic test_random_sessions();
    cfg_t c;
    for (int s = 0; s < 7; s++) begin
      case (s)
        0: c = '0;
        1: c = '{8'd254, 8'd254, 14'd16383, 8'd254, 14'd16383, 16'd65534, 16'd65534};
        2: c = '{START_HOLD_RST, STOP_HOLD_RST, CUTOFF_MV_RST, CUTOFF_TICKS_RST,
                 WARN_MV_RST, BLINK_OFF_RST, BLINK_ON_RST};
        default: c = random_thresholds();
      endcase
      gap_odds = pick_odds();
      stall_odds = pick_odds();
      program_thresholds(c);
      random_traffic((s == 1) ? 500 : 110);
    end
  endtask

  task automatic test_backpressure();
    gap_odds = 0;
    stall_odds = 0;
    program_thresholds(random_thresholds());
    steer_to_run();
    long_hold_req = 1'b1;
    random_traffic(40);
    wait_for_results();
    random_traffic(30);
  endtask

  task automatic test_blink();
    cfg_t c;
    c = '{8'd0, 8'd254, 14'd0, 8'd0, 14'd0, 16'd3, 16'd5};
    gap_odds = 0;
    stall_odds = 0;
    program_thresholds(c);
    steer_to_run();
    repeat (40) send_tick(1'b0, 1'(($urandom_range(0, 1))), 12'($urandom_range(0, 4095)));
    c.warn_mv = 14'd16383;
    program_thresholds(c);
    repeat (30) send_tick(1'b0, 1'b0, 12'd0);
  endtask

  task automatic test_steady_stream();
    gap_odds = 0;
    stall_odds = 0;
    program_thresholds(random_thresholds());
    random_traffic(100);
  endtask

  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    seq_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (predicted_outputs.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = predicted_outputs.pop_front();
        if (rails_on !== want.rails) begin
          $error("rails_on: expected %0d, got %0d", want.rails, rails_on);
          mismatches++;
        end
        if (green_led !== want.green) begin
          $error("green_led: expected %0d, got %0d", want.green, green_led);
          mismatches++;
        end
        if (orange_led !== want.orange) begin
          $error("orange_led: expected %0d, got %0d", want.orange, orange_led);
          mismatches++;
        end
        if (mode !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, mode);
          mismatches++;
        end
        if (battery_mv !== want.mv) begin
          $error("battery_mv: expected %0d, got %0d", want.mv, battery_mv);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_sessions();
    test_backpressure();
    test_blink();
    test_steady_stream();
    wait_for_results();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && predicted_outputs.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
